### rtl/vbn_pkg.sv
// Shared widths, codes and limits for the vertex box normalizer.
// Used by vbn_div and vertex_box_normalizer_top; depends on nothing.
`default_nettype none

package vbn_pkg;

  // Field widths of the stream payloads
  localparam int COORD_W  = 32;
  localparam int IDX_W    = 10;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int NORM_W   = 18;
  localparam int COUNT_W  = 11;
  localparam int AXES     = 3;

  // tdata: fields packed from bit 0, padded to whole bytes
  localparam int S_DATA_BITS = AXES * COORD_W + IDX_W;
  localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = AXES * NORM_W + COUNT_W;
  localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

  // Arithmetic widths
  localparam int EXT_W       = COORD_W;          // axis extent, unsigned
  localparam int DIFF_W      = COORD_W + 1;      // vertex minus center, signed
  localparam int MAG_W       = DIFF_W;           // magnitude of the difference
  localparam int DEN_W       = EXT_W + 3;        // 5 * extent
  localparam int SCALE_SHIFT = 19;               // 1.6 * 65536 = 2^19 / 5
  localparam int QUO_W       = 17;               // quotient stays below 2^17
  localparam int PRE_SHIFT   = SCALE_SHIFT - QUO_W;
  localparam int REM_W       = MAG_W + PRE_SHIFT;
  localparam int STEP_W      = $clog2(QUO_W);

  // Saturation limit of a normalized coordinate (1.0 in Q1.16)
  localparam logic [QUO_W-1:0] NORM_LIMIT = QUO_W'(65536);

  // Bounds after reset or clear
  localparam logic [COORD_W-1:0] COORD_POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_LOAD  = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_READ  = KIND_W'(2);

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_FULL  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_RANGE = STATUS_W'(2);

endpackage

`default_nettype wire

### rtl/vbn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; used for the vertex store of vertex_box_normalizer_top.
`default_nettype none

module vbn_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/vbn_div.sv
// Three-lane restoring divider, one quotient bit per lane per cycle.
// Computes (num << 19) / den for each axis. Depends on vbn_pkg.
`default_nettype none

module vbn_div (
  input  wire logic                                                    clk,
  input  wire logic                                                    rst,
  input  wire logic                                                    start,
  input  wire logic [vbn_pkg::AXES-1:0][vbn_pkg::MAG_W-1:0]            num,
  input  wire logic [vbn_pkg::DEN_W-1:0]                               den,
  output logic                                                         done,
  output logic      [vbn_pkg::AXES-1:0][vbn_pkg::QUO_W-1:0]            quo
);

  localparam logic [vbn_pkg::STEP_W-1:0] LAST_STEP = vbn_pkg::STEP_W'(vbn_pkg::QUO_W - 1);

  logic                                               busy;
  logic [vbn_pkg::STEP_W-1:0]                         step;
  logic [vbn_pkg::AXES-1:0][vbn_pkg::REM_W-1:0]       rem;
  logic [vbn_pkg::AXES-1:0][vbn_pkg::REM_W-1:0]       rem_next;
  logic [vbn_pkg::AXES-1:0]                           qbit;
  logic [vbn_pkg::AXES-1:0][vbn_pkg::REM_W:0]         shifted;
  logic [vbn_pkg::REM_W:0]                            den_ext;

  // One trial subtraction per lane
  always_comb begin
    den_ext = (vbn_pkg::REM_W + 1)'(den);
    for (int a = 0; a < vbn_pkg::AXES; a++) begin
      shifted[a]  = {rem[a], 1'b0};
      qbit[a]     = (shifted[a] >= den_ext);
      rem_next[a] = qbit[a] ? vbn_pkg::REM_W'(shifted[a] - den_ext)
                            : vbn_pkg::REM_W'(shifted[a]);
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + vbn_pkg::STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainders and quotients; the low dividend bits are all zero,
  // so the top part of num << 19 seeds the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      for (int a = 0; a < vbn_pkg::AXES; a++) begin
        rem[a] <= vbn_pkg::REM_W'(num[a]) << vbn_pkg::PRE_SHIFT;
        quo[a] <= '0;
      end
    end else if (busy) begin
      for (int a = 0; a < vbn_pkg::AXES; a++) begin
        rem[a] <= rem_next[a];
        quo[a] <= {quo[a][vbn_pkg::QUO_W-2:0], qbit[a]};
      end
    end
  end

endmodule

`default_nettype wire

### rtl/vertex_box_normalizer_top.sv
// Vertex box normalizer: stores Q15.16 vertices in one RAM, tracks per-axis
// bounds and returns a stored vertex normalized into -0.8 .. 1.0 (Q1.16).
// Every request gives one result. One request is in work at a time; the next
// is taken once the current result sits in the output register, even while
// that result still waits for m_tready. A clear, a rejected load, a read past
// the count or an unknown kind goes from ST_IDLE straight to ST_OUT; a load
// passes ST_LOAD (one RAM write plus the bound update); a read passes four
// setup stages (ST_PREP, ST_CENTER, ST_DIFF, ST_ABS) after the RAM read, then
// the 17-step restoring divider that runs the three axes in parallel, or skips
// the divider when every axis extent is zero. No clearing pass is needed after
// reset. Depends on vbn_pkg, vbn_ram and vbn_div.
`default_nettype none

module vertex_box_normalizer_top #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Request side
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [vbn_pkg::S_DATA_W-1:0]  s_tdata,   // coord_x, coord_y, coord_z, vertex_index
  input  wire logic [vbn_pkg::KIND_W-1:0]    s_tuser,   // kind
  // Result side
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [vbn_pkg::M_DATA_W-1:0]  m_tdata,   // norm_x, norm_y, norm_z, stored_count
  output logic      [vbn_pkg::STATUS_W-1:0]  m_tuser    // status
);

  localparam int AW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW     = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W  = (CW > vbn_pkg::IDX_W) ? CW : vbn_pkg::IDX_W;
  localparam int VERT_W = vbn_pkg::AXES * vbn_pkg::COORD_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOAD   = 8'b0000_0010,
    ST_PREP   = 8'b0000_0100,
    ST_CENTER = 8'b0000_1000,
    ST_DIFF   = 8'b0001_0000,
    ST_ABS    = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  state_t state;

  // Control and bound state
  logic [CW-1:0]                        held_count;
  logic signed [vbn_pkg::COORD_W-1:0]   low  [vbn_pkg::AXES];
  logic signed [vbn_pkg::COORD_W-1:0]   high [vbn_pkg::AXES];

  // Per-request working registers
  logic signed [vbn_pkg::COORD_W-1:0]   coord  [vbn_pkg::AXES];
  logic signed [vbn_pkg::COORD_W-1:0]   vert   [vbn_pkg::AXES];
  logic signed [vbn_pkg::COORD_W-1:0]   center [vbn_pkg::AXES];
  logic        [vbn_pkg::EXT_W-1:0]     ext_axis [vbn_pkg::AXES];
  logic signed [vbn_pkg::DIFF_W-1:0]    diff   [vbn_pkg::AXES];
  logic        [vbn_pkg::AXES-1:0]      neg;
  logic        [vbn_pkg::EXT_W-1:0]     ext_max;
  logic        [vbn_pkg::DEN_W-1:0]     den;
  logic        [vbn_pkg::STATUS_W-1:0]  res_status;
  logic        [vbn_pkg::NORM_W-1:0]    res_norm [vbn_pkg::AXES];

  // Request fields
  logic                                 accept;
  logic [vbn_pkg::KIND_W-1:0]           in_kind;
  logic [vbn_pkg::IDX_W-1:0]            in_idx;
  logic signed [vbn_pkg::COORD_W-1:0]   in_coord [vbn_pkg::AXES];
  logic                                 full;
  logic                                 idx_over;

  // Datapath helpers
  logic [vbn_pkg::EXT_W-1:0]                          ext_xy;
  logic [vbn_pkg::AXES-1:0][vbn_pkg::MAG_W-1:0]       mag;
  logic [vbn_pkg::AXES-1:0][vbn_pkg::QUO_W-1:0]       quo;
  logic [vbn_pkg::QUO_W-1:0]                          quo_sat [vbn_pkg::AXES];
  logic                                               div_start;
  logic                                               div_done;

  // RAM ports
  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [VERT_W-1:0]    ram_wr_data;
  logic                 ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  logic [VERT_W-1:0]    ram_rd_data;

  // Request unpacking and checks
  always_comb begin
    accept  = s_tvalid && s_tready;
    in_kind = s_tuser;
    in_idx  = s_tdata[vbn_pkg::AXES*vbn_pkg::COORD_W +: vbn_pkg::IDX_W];
    for (int a = 0; a < vbn_pkg::AXES; a++) begin
      in_coord[a] = $signed(s_tdata[a*vbn_pkg::COORD_W +: vbn_pkg::COORD_W]);
    end
    full     = (held_count == CW'(MAX_VERTICES));
    idx_over = (CMP_W'(in_idx) >= CMP_W'(held_count));
  end

  // No request is taken while reset is held
  assign s_tready = (state == ST_IDLE) && !rst;

  // Vertex store: x in the low word, z in the high word
  assign ram_wr_en   = (state == ST_LOAD);
  assign ram_wr_addr = AW'(held_count);
  assign ram_wr_data = {coord[2], coord[1], coord[0]};
  assign ram_rd_en   = accept && (in_kind == vbn_pkg::KIND_READ) && !idx_over;
  assign ram_rd_addr = AW'(in_idx);

  vbn_ram #(
    .WIDTH (VERT_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Largest extent, magnitudes for the divider, saturated quotients
  always_comb begin
    ext_xy = (ext_axis[0] > ext_axis[1]) ? ext_axis[0] : ext_axis[1];
    for (int a = 0; a < vbn_pkg::AXES; a++) begin
      mag[a]     = diff[a][vbn_pkg::DIFF_W-1] ? vbn_pkg::MAG_W'(-diff[a])
                                               : vbn_pkg::MAG_W'(diff[a]);
      quo_sat[a] = (quo[a] > vbn_pkg::NORM_LIMIT) ? vbn_pkg::NORM_LIMIT : quo[a];
    end
    div_start = (state == ST_ABS) && (ext_max != '0);
  end

  vbn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mag),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // Sequencer, count, bounds and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
      m_tvalid   <= 1'b0;
      for (int a = 0; a < vbn_pkg::AXES; a++) begin
        low[a]  <= vbn_pkg::COORD_POS_MAX;
        high[a] <= vbn_pkg::COORD_NEG_MIN;
      end
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_OUT;
            case (in_kind)
              vbn_pkg::KIND_CLEAR: begin
                held_count <= '0;
                for (int a = 0; a < vbn_pkg::AXES; a++) begin
                  low[a]  <= vbn_pkg::COORD_POS_MAX;
                  high[a] <= vbn_pkg::COORD_NEG_MIN;
                end
              end
              vbn_pkg::KIND_LOAD: begin
                if (!full) begin
                  state <= ST_LOAD;
                end
              end
              vbn_pkg::KIND_READ: begin
                if (!idx_over) begin
                  state <= ST_PREP;
                end
              end
              default: begin
                state <= ST_OUT;
              end
            endcase
          end
        end
        ST_LOAD: begin
          held_count <= held_count + CW'(1);
          for (int a = 0; a < vbn_pkg::AXES; a++) begin
            if (coord[a] < low[a]) begin
              low[a] <= coord[a];
            end
            if (coord[a] > high[a]) begin
              high[a] <= coord[a];
            end
          end
          state <= ST_OUT;
        end
        ST_PREP:   state <= ST_CENTER;
        ST_CENTER: state <= ST_DIFF;
        ST_DIFF:   state <= ST_ABS;
        ST_ABS: begin
          state <= (ext_max == '0) ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, one step of the read per state
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        for (int a = 0; a < vbn_pkg::AXES; a++) begin
          coord[a]    <= in_coord[a];
          res_norm[a] <= '0;
        end
        res_status <= vbn_pkg::STATUS_OK;
        if (in_kind == vbn_pkg::KIND_LOAD && full) begin
          res_status <= vbn_pkg::STATUS_FULL;
        end
        if (in_kind == vbn_pkg::KIND_READ && idx_over) begin
          res_status <= vbn_pkg::STATUS_RANGE;
        end
      end
      ST_PREP: begin
        // extents are exact in 32 bits once a vertex is held
        for (int a = 0; a < vbn_pkg::AXES; a++) begin
          vert[a]     <= $signed(ram_rd_data[a*vbn_pkg::COORD_W +: vbn_pkg::COORD_W]);
          ext_axis[a] <= vbn_pkg::EXT_W'(high[a] - low[a]);
        end
      end
      ST_CENTER: begin
        // center = low + floor(extent / 2)
        for (int a = 0; a < vbn_pkg::AXES; a++) begin
          center[a] <= low[a] + $signed({1'b0, ext_axis[a][vbn_pkg::EXT_W-1:1]});
        end
        ext_max <= (ext_xy > ext_axis[2]) ? ext_xy : ext_axis[2];
      end
      ST_DIFF: begin
        for (int a = 0; a < vbn_pkg::AXES; a++) begin
          diff[a] <= vbn_pkg::DIFF_W'(vert[a]) - vbn_pkg::DIFF_W'(center[a]);
        end
        den <= (vbn_pkg::DEN_W'(ext_max) << 2) + vbn_pkg::DEN_W'(ext_max);
      end
      ST_ABS: begin
        for (int a = 0; a < vbn_pkg::AXES; a++) begin
          neg[a] <= diff[a][vbn_pkg::DIFF_W-1];
        end
      end
      ST_DIV: begin
        // restore the sign; truncation toward zero comes from the magnitude
        if (div_done) begin
          for (int a = 0; a < vbn_pkg::AXES; a++) begin
            res_norm[a] <= neg[a] ? vbn_pkg::NORM_W'(-{1'b0, quo_sat[a]})
                                  : vbn_pkg::NORM_W'({1'b0, quo_sat[a]});
          end
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= vbn_pkg::M_DATA_W'({vbn_pkg::COUNT_W'(held_count),
                                          res_norm[2], res_norm[1], res_norm[0]});
          m_tuser <= res_status;
        end
      end
      default: begin
        res_status <= vbn_pkg::STATUS_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

### sim/tb_vertex_box_normalizer_top.sv
// Testbench for vertex_box_normalizer_top: loads, reads and clears vertex
// stores and checks every result against an in-bench normalizer model.
// Depends on vbn_pkg and the RTL of vertex_box_normalizer_top.
`default_nettype none

module tb_vertex_box_normalizer_top;
  import vbn_pkg::*;

  localparam int MAX_VTX = 1024;
  localparam logic [KIND_W-1:0] KIND_UNUSED = KIND_W'(3);
  localparam longint NORM_SAT = 65536;
  localparam int PRINT_CAP = 30;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NORM_W-1:0]   nx;
    logic [NORM_W-1:0]   ny;
    logic [NORM_W-1:0]   nz;
    logic [COUNT_W-1:0]  count;
  } norm_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // coord_x, coord_y, coord_z, vertex_index
  logic [KIND_W-1:0]   s_tuser;   // kind
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;   // norm_x, norm_y, norm_z, stored_count
  logic [STATUS_W-1:0] m_tuser;   // status

  // Normalizer model state
  int     vtx [3][MAX_VTX];
  int     held;
  longint box_lo [3];
  longint box_hi [3];

  norm_result_t awaited_norms [$];

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int mismatches    = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int reads_ok      = 0;
  int full_hits     = 0;
  int past_reads    = 0;
  int odd_kinds     = 0;

  always #5 clk = ~clk;

  vertex_box_normalizer_top #(.MAX_VERTICES(MAX_VTX)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Model: bounds back to their empty values
  task automatic empty_box();
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 64'sd2147483647;
      box_hi[a] = -64'sd2147483648;
    end
  endtask

  // Model: one request in, one normalized result out
  task automatic normalize_request(input logic [KIND_W-1:0] kind, input int x, y, z,
                                   input logic [IDX_W-1:0] idx, output norm_result_t r);
    longint c [3];
    longint ext, e, center, d, n;
    logic [NORM_W-1:0] nv [3];
    c[0] = x;
    c[1] = y;
    c[2] = z;
    for (int a = 0; a < 3; a++) nv[a] = '0;
    r = '0;
    r.status = STATUS_OK;
    case (kind)
      KIND_CLEAR: begin
        held = 0;
        empty_box();
      end
      KIND_LOAD: begin
        if (held >= MAX_VTX) begin
          r.status = STATUS_FULL;
        end else begin
          for (int a = 0; a < 3; a++) begin
            vtx[a][held] = int'(c[a]);
            if (c[a] < box_lo[a]) box_lo[a] = c[a];
            if (c[a] > box_hi[a]) box_hi[a] = c[a];
          end
          held++;
        end
      end
      KIND_READ: begin
        if (int'(idx) >= held) begin
          r.status = STATUS_RANGE;
        end else begin
          // largest axis extent sets the common scale
          ext = 0;
          for (int a = 0; a < 3; a++) begin
            e = box_hi[a] - box_lo[a];
            if (e > ext) ext = e;
          end
          for (int a = 0; a < 3; a++) begin
            center = box_lo[a] + (box_hi[a] - box_lo[a]) / 2;
            d = longint'(vtx[a][idx]) - center;
            if (ext != 0) n = (d * 64'sd524288) / (64'sd5 * ext);
            else n = d;
            if (n > NORM_SAT) n = NORM_SAT;
            if (n < -NORM_SAT) n = -NORM_SAT;
            nv[a] = n[NORM_W-1:0];
          end
        end
      end
      default: ;  // unknown kind leaves everything alone
    endcase
    r.nx = nv[0];
    r.ny = nv[1];
    r.nz = nv[2];
    r.count = held[COUNT_W-1:0];
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Sender: optional idle gap, then hold the request until accepted
  task automatic send_item(input logic [KIND_W-1:0] kind, input int x, y, z,
                           input logic [IDX_W-1:0] idx);
    logic [S_DATA_W-1:0] word;
    norm_result_t r;
    int gaps;
    gaps = 0;
    while ($urandom_range(0, 99) < src_idle_pct && gaps < 40) gaps++;
    if (gaps > 0) begin
      s_tvalid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    word = '0;
    word[0 +: COORD_W]           = x;
    word[COORD_W +: COORD_W]     = y;
    word[2 * COORD_W +: COORD_W] = z;
    word[3 * COORD_W +: IDX_W]   = idx;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    normalize_request(kind, x, y, z, idx, r);
    awaited_norms.push_back(r);
    requests_sent++;
    if (kind == KIND_READ && r.status == STATUS_OK) reads_ok++;
    if (r.status == STATUS_FULL) full_hits++;
    if (r.status == STATUS_RANGE) past_reads++;
    if (kind == KIND_UNUSED) odd_kinds++;
  endtask

  task automatic send_load(input int x, y, z);
    send_item(KIND_LOAD, x, y, z, IDX_W'($urandom));
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    send_item(KIND_READ, int'($urandom), int'($urandom), int'($urandom), idx);
  endtask

  task automatic send_clear();
    send_item(KIND_CLEAR, int'($urandom), int'($urandom), int'($urandom), IDX_W'($urandom));
  endtask

  // Sender holds off until every pending result is back
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_norms.size() != 0);
  endtask

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // Coordinate near a per-run base; span is the width of the spread in bits
  function automatic int box_coord(input int base, input int span);
    if ($urandom_range(0, 15) == 0)
      return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
    if (span >= 32) return int'($urandom);
    return base + int'($urandom & ((32'd1 << span) - 32'd1));
  endfunction

  function automatic logic [IDX_W-1:0] valid_index();
    if (held == 0 || (held < MAX_VTX && $urandom_range(0, 9) == 0))
      return IDX_W'($urandom_range(held, MAX_VTX - 1));
    return IDX_W'($urandom_range(0, held - 1));
  endfunction

  // Field extremes, zero extent, odd extents, every kind, the ok and range statuses
  task automatic test_directed();
    send_clear();
    send_read(0);                          // empty store
    send_item(KIND_UNUSED, 0, 0, 0, 0);
    send_load(32'h00010000, -32'sh00010000, 0);
    send_read(0);                          // single vertex, zero extent
    send_load(32'h00010000, -32'sh00010000, 0);
    send_read(1);
    send_load(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_load(32'h80000000, 32'h7fffffff, 32'h80000000);
    send_read(2);
    send_read(3);
    send_read(0);
    send_read(10'h3ff);                    // far past the count
    send_read(4);                          // index equal to the count
    send_clear();
    send_read(0);
    send_load(5, -3, 100);
    send_load(-7, 9, 100);                 // even extents, exact half
    send_read(0);
    send_read(1);
    send_item(KIND_UNUSED, -1, -1, -1, 10'h3ff);
    send_load(-1, -1, -1);
    send_read(2);
    send_clear();
  endtask

  // Fill the store to capacity, then hit the full case and the last entry
  task automatic test_fill();
    int base [3];
    int span [3];
    for (int a = 0; a < 3; a++) begin
      base[a] = int'($urandom);
      span[a] = $urandom_range(4, 32);
    end
    send_clear();
    repeat (MAX_VTX) send_load(box_coord(base[0], span[0]), box_coord(base[1], span[1]),
                               box_coord(base[2], span[2]));
    send_load(1, 2, 3);
    send_load(int'($urandom), int'($urandom), int'($urandom));
    send_read(IDX_W'(MAX_VTX - 1));
    send_read(0);
    repeat (8) send_read(IDX_W'($urandom));
    send_item(KIND_UNUSED, int'($urandom), int'($urandom), int'($urandom), 10'h2aa);
    send_clear();
    send_read(IDX_W'(MAX_VTX - 1));
  endtask

  // Mostly load-read runs with random boxes, most after a clear, some noise in between
  task automatic test_random(input int n);
    int start, pick, nload, nread;
    int base [3];
    int span [3];
    int v [3];
    start = requests_sent;
    while (requests_sent - start < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if (pick < 5) send_clear();
        for (int a = 0; a < 3; a++) begin
          base[a] = int'($urandom);
          span[a] = $urandom_range(0, 32);
        end
        nload = $urandom_range(1, 20);
        repeat (nload) send_load(box_coord(base[0], span[0]), box_coord(base[1], span[1]),
                                 box_coord(base[2], span[2]));
        nread = $urandom_range(1, 10);
        repeat (nread) send_read(valid_index());
      end else if (pick == 7) begin
        send_item(KIND_UNUSED, int'($urandom), int'($urandom), int'($urandom),
                  IDX_W'($urandom));
        send_read(IDX_W'($urandom));
      end else if (pick == 8) begin
        send_read(IDX_W'($urandom));
      end else begin
        // repeated vertex keeps the extent at zero
        for (int a = 0; a < 3; a++) v[a] = int'($urandom);
        send_clear();
        send_load(v[0], v[1], v[2]);
        send_load(v[0], v[1], v[2]);
        send_read(0);
        send_read(1);
      end
    end
  endtask

  // Result side: random back-pressure, check each accepted result in order
  always @(posedge clk) begin : result_check
    norm_result_t want;
    if (m_tvalid && m_tready) begin
      results_seen++;
      if (awaited_norms.size() == 0) begin
        report_mismatch("result with nothing pending, status", m_tuser, 0);
      end else begin
        want = awaited_norms.pop_front();
        if (m_tuser != want.status)
          report_mismatch("status", m_tuser, want.status);
        if (m_tdata[0 +: NORM_W] != want.nx)
          report_mismatch("norm_x", $signed(m_tdata[0 +: NORM_W]), $signed(want.nx));
        if (m_tdata[NORM_W +: NORM_W] != want.ny)
          report_mismatch("norm_y", $signed(m_tdata[NORM_W +: NORM_W]), $signed(want.ny));
        if (m_tdata[2 * NORM_W +: NORM_W] != want.nz)
          report_mismatch("norm_z", $signed(m_tdata[2 * NORM_W +: NORM_W]),
                          $signed(want.nz));
        if (m_tdata[3 * NORM_W +: COUNT_W] != want.count)
          report_mismatch("stored_count", m_tdata[3 * NORM_W +: COUNT_W], want.count);
      end
    end
    m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Run sequence
  initial begin
    held = 0;
    empty_box();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = KIND_CLEAR;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_idling(0, 0);
    test_directed();
    hold_until_drained();
    set_idling(20, 20);
    test_fill();
    hold_until_drained();
    set_idling(0, 0);
    test_random(150);
    set_idling(78, 0);
    test_random(150);
    hold_until_drained();
    set_idling(0, 78);
    test_random(150);
    set_idling(20, 20);
    test_random(150);
    set_idling(0, 0);
    test_random(100);

    hold_until_drained();
    repeat (30) @(posedge clk);
    $display("Covered %0d requests, %0d results: %0d normalized reads, %0d full-store loads,",
             requests_sent, results_seen, reads_ok, full_hits);
    $display("%0d reads past the count, %0d unknown kinds, across four idle/stall mixes.",
             past_reads, odd_kinds);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Timeout with %0d results still pending", awaited_norms.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

### vertex_box_normalizer_top.f
rtl/vbn_pkg.sv
rtl/vbn_ram.sv
rtl/vbn_div.sv
rtl/vertex_box_normalizer_top.sv
sim/tb_vertex_box_normalizer_top.sv
